// ===== hdl/ethcls_pkg.sv =====
// ============================================================================
// Ethernet classifier package
// Shared types, register map and header constants for the frame classifier.
// ============================================================================
package ethcls_pkg;

  // Default storage sizes handed to the top level.
  localparam int MAX_FRAME_DEFAULT   = 2048;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Width of the reported length, and its largest value.
  localparam int LEN_W   = 12;
  localparam int LEN_MAX = 4095;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_COPY_LIMIT     = 3'd0;
  localparam logic [2:0] REG_HTTP_PORT      = 3'd1;
  localparam logic [2:0] REG_IPV4_ETHERTYPE = 3'd2;
  localparam logic [2:0] REG_VLAN_ETHERTYPE = 3'd3;
  localparam logic [2:0] REG_TCP_PROTOCOL   = 3'd4;

  // Register reset values.
  localparam logic [11:0] RST_COPY_LIMIT     = 12'd2048;
  localparam logic [15:0] RST_HTTP_PORT      = 16'd80;
  localparam logic [15:0] RST_IPV4_ETHERTYPE = 16'h0800;
  localparam logic [15:0] RST_VLAN_ETHERTYPE = 16'h8100;
  localparam logic [7:0]  RST_TCP_PROTOCOL   = 8'd6;

  // Header byte positions and minimum lengths.
  localparam logic [4:0] IPO_PLAIN     = 5'd14;
  localparam logic [4:0] IPO_VLAN      = 5'd18;
  localparam int         ETYPE_HI_POS  = 12;
  localparam int         ETYPE_LO_POS  = 13;
  localparam int         INNER_HI_POS  = 16;
  localparam int         INNER_LO_POS  = 17;
  localparam int         PROTO_OFS     = 9;
  localparam int         DPORT_HI_OFS  = 2;
  localparam int         DPORT_LO_OFS  = 3;
  localparam int         DOFS_OFS      = 12;
  localparam int         NEED_PROTO    = 10;
  localparam int         NEED_DPORT    = 4;
  localparam int         NEED_DOFS     = 13;

  typedef enum logic [2:0] {
    VERDICT_NOT_IPV4  = 3'd0,
    VERDICT_NOT_TCP   = 3'd1,
    VERDICT_TCP_OTHER = 3'd2,
    VERDICT_TCP_HTTP  = 3'd3,
    VERDICT_SHORT     = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [11:0] copy_limit;
    logic [15:0] http_port;
    logic [15:0] ipv4_ethertype;
    logic [15:0] vlan_ethertype;
    logic [7:0]  tcp_protocol;
  } cfg_t;

  // Everything the back end needs about one finished frame.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             vlan_seen;
    logic [15:0]      type_word;
    logic [3:0]       header_words;
    logic [7:0]       proto_seen;
    logic [15:0]      dest_port_seen;
    logic [3:0]       data_words;
  } frame_sum_t;

endpackage

// ===== hdl/ethcls_regs.sv =====
// ============================================================================
// Ethernet classifier configuration registers
// APB-style register file holding the classification settings.
// ============================================================================
module ethcls_regs import ethcls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_COPY_LIMIT:     cfg_d.copy_limit     = pwdata[11:0];
        REG_HTTP_PORT:      cfg_d.http_port      = pwdata[15:0];
        REG_IPV4_ETHERTYPE: cfg_d.ipv4_ethertype = pwdata[15:0];
        REG_VLAN_ETHERTYPE: cfg_d.vlan_ethertype = pwdata[15:0];
        REG_TCP_PROTOCOL:   cfg_d.tcp_protocol   = pwdata[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COPY_LIMIT:     prdata = APB_DATA_W'(cfg_q.copy_limit);
      REG_HTTP_PORT:      prdata = APB_DATA_W'(cfg_q.http_port);
      REG_IPV4_ETHERTYPE: prdata = APB_DATA_W'(cfg_q.ipv4_ethertype);
      REG_VLAN_ETHERTYPE: prdata = APB_DATA_W'(cfg_q.vlan_ethertype);
      REG_TCP_PROTOCOL:   prdata = APB_DATA_W'(cfg_q.tcp_protocol);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.copy_limit     <= RST_COPY_LIMIT;
      cfg_q.http_port      <= RST_HTTP_PORT;
      cfg_q.ipv4_ethertype <= RST_IPV4_ETHERTYPE;
      cfg_q.vlan_ethertype <= RST_VLAN_ETHERTYPE;
      cfg_q.tcp_protocol   <= RST_TCP_PROTOCOL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/ethcls_front.sv =====
// ============================================================================
// Ethernet classifier front end
// Byte-position header capture; emits one frame summary per final byte.
// ============================================================================
module ethcls_front import ethcls_pkg::*; #(
  parameter int MaxFrame = MAX_FRAME_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] frame_byte_i,
  input  logic       end_of_frame_i,
  input  cfg_t       cfg_i,
  output logic       push_o,
  output frame_sum_t sum_o
);

  localparam int             LenW   = $clog2(MaxFrame + 1);
  localparam int             WideW  = (LenW > LEN_W) ? LenW : LEN_W;
  localparam logic [LenW-1:0] MaxIdx = LenW'(MaxFrame);

  logic [LenW-1:0] idx_q, idx_d;
  logic            vlan_q, vlan_d;
  logic [15:0]     type_q, type_d;
  logic [3:0]      hw_q, hw_d;
  logic [7:0]      proto_q, proto_d;
  logic [15:0]     dport_q, dport_d;
  logic [3:0]      dw_q, dw_d;

  logic [4:0]       ipo;
  logic [6:0]       tcpo;
  logic [LenW-1:0]  ipo_w, tcpo_w;
  logic [WideW-1:0] len_wide;

  assign ipo    = vlan_q ? IPO_VLAN : IPO_PLAIN;
  assign tcpo   = 7'(ipo) + {1'b0, hw_q, 2'b00};
  assign ipo_w  = LenW'(ipo);
  assign tcpo_w = LenW'(tcpo);

  always_comb begin
    idx_d   = idx_q;
    vlan_d  = vlan_q;
    type_d  = type_q;
    hw_d    = hw_q;
    proto_d = proto_q;
    dport_d = dport_q;
    dw_d    = dw_q;
    // Bytes past the maximum frame size are counted no further and parse nothing.
    if (idx_q < MaxIdx) begin
      if (idx_q == LenW'(ETYPE_HI_POS) || idx_q == LenW'(ETYPE_LO_POS) ||
          (vlan_q && (idx_q == LenW'(INNER_HI_POS) || idx_q == LenW'(INNER_LO_POS)))) begin
        type_d = {type_q[7:0], frame_byte_i};
      end
      if (idx_q == LenW'(ETYPE_LO_POS)) begin
        vlan_d = (type_d == cfg_i.vlan_ethertype);
      end
      if (idx_q == ipo_w) begin
        hw_d = frame_byte_i[3:0];
      end
      if (idx_q == ipo_w + LenW'(PROTO_OFS)) begin
        proto_d = frame_byte_i;
      end
      if (idx_q > ipo_w) begin
        if (idx_q == tcpo_w + LenW'(DPORT_HI_OFS) ||
            idx_q == tcpo_w + LenW'(DPORT_LO_OFS)) begin
          dport_d = {dport_q[7:0], frame_byte_i};
        end
        if (idx_q == tcpo_w + LenW'(DOFS_OFS)) begin
          dw_d = frame_byte_i[7:4];
        end
      end
      idx_d = idx_q + LenW'(1);
    end
  end

  // The length is clipped to what the length field can hold; the copy limit
  // never exceeds that, so the clipped value gives the same kept length.
  assign len_wide = WideW'(idx_d);

  always_comb begin
    sum_o.len            = (len_wide > WideW'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                        : len_wide[LEN_W-1:0];
    sum_o.vlan_seen      = vlan_d;
    sum_o.type_word      = type_d;
    sum_o.header_words   = hw_d;
    sum_o.proto_seen     = proto_d;
    sum_o.dest_port_seen = dport_d;
    sum_o.data_words     = dw_d;
  end

  assign push_o = accept_i && end_of_frame_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      vlan_q  <= 1'b0;
      type_q  <= '0;
      hw_q    <= '0;
      proto_q <= '0;
      dport_q <= '0;
      dw_q    <= '0;
    end else if (accept_i) begin
      if (end_of_frame_i) begin
        idx_q   <= '0;
        vlan_q  <= 1'b0;
        type_q  <= '0;
        hw_q    <= '0;
        proto_q <= '0;
        dport_q <= '0;
        dw_q    <= '0;
      end else begin
        idx_q   <= idx_d;
        vlan_q  <= vlan_d;
        type_q  <= type_d;
        hw_q    <= hw_d;
        proto_q <= proto_d;
        dport_q <= dport_d;
        dw_q    <= dw_d;
      end
    end
  end

endmodule

// ===== hdl/ethcls_queue.sv =====
// ============================================================================
// Ethernet classifier summary queue
// Small FIFO of frame summaries between the front end and the back end.
// ============================================================================
module ethcls_queue import ethcls_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_sum_t push_data_i,
  input  logic       pop_i,
  output frame_sum_t head_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  frame_sum_t      entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/ethcls_back.sv =====
// ============================================================================
// Ethernet classifier back end
// Turns a frame summary into the verdict, offsets and kept length.
// ============================================================================
module ethcls_back import ethcls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_sum_t  head_i,
  input  logic        empty_i,
  input  cfg_t        cfg_i,
  output logic        pop_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [2:0]  verdict_o,
  output logic [4:0]  ip_offset_o,
  output logic [6:0]  tcp_offset_o,
  output logic [7:0]  payload_offset_o,
  output logic [11:0] kept_length_o
);

  logic        valid_q;
  logic        load;
  verdict_e    verdict_d, verdict_q;
  logic [4:0]  ipo_d, ipo_q, ipo;
  logic [6:0]  tcpo_d, tcpo_q, tcpo;
  logic [7:0]  pay_d, pay_q;
  logic [11:0] kept_d, kept_q, clipped, len;

  assign len     = head_i.len;
  assign ipo     = head_i.vlan_seen ? IPO_VLAN : IPO_PLAIN;
  assign tcpo    = 7'(ipo) + {1'b0, head_i.header_words, 2'b00};
  assign clipped = (len < cfg_i.copy_limit) ? len : cfg_i.copy_limit;

  // Checks run in header order; the first one that fails decides.
  always_comb begin
    verdict_d = VERDICT_SHORT;
    ipo_d     = '0;
    tcpo_d    = '0;
    pay_d     = '0;
    kept_d    = '0;
    if (len < 12'(IPO_PLAIN) || (head_i.vlan_seen && len < 12'(IPO_VLAN))) begin
      verdict_d = VERDICT_SHORT;
    end else if (head_i.type_word != cfg_i.ipv4_ethertype) begin
      verdict_d = VERDICT_NOT_IPV4;
    end else if (len < 12'(ipo) + 12'(NEED_PROTO)) begin
      verdict_d = VERDICT_SHORT;
    end else if (head_i.proto_seen != cfg_i.tcp_protocol) begin
      verdict_d = VERDICT_NOT_TCP;
      ipo_d     = ipo;
    end else if (len < 12'(tcpo) + 12'(NEED_DPORT)) begin
      verdict_d = VERDICT_SHORT;
    end else if (head_i.dest_port_seen != cfg_i.http_port) begin
      verdict_d = VERDICT_TCP_OTHER;
      ipo_d     = ipo;
      tcpo_d    = tcpo;
      kept_d    = clipped;
    end else if (len < 12'(tcpo) + 12'(NEED_DOFS)) begin
      verdict_d = VERDICT_SHORT;
    end else begin
      verdict_d = VERDICT_TCP_HTTP;
      ipo_d     = ipo;
      tcpo_d    = tcpo;
      pay_d     = 8'(tcpo) + {2'b00, head_i.data_words, 2'b00};
      kept_d    = clipped;
    end
  end

  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      ipo_q     <= ipo_d;
      tcpo_q    <= tcpo_d;
      pay_q     <= pay_d;
      kept_q    <= kept_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign verdict_o        = verdict_q;
  assign ip_offset_o      = ipo_q;
  assign tcp_offset_o     = tcpo_q;
  assign payload_offset_o = pay_q;
  assign kept_length_o    = kept_q;

endmodule

// ===== hdl/eth_ipv4_tcp_http_classifier.sv =====
// ============================================================================
// Ethernet / IPv4 / TCP / HTTP frame classifier
// Parses a frame byte per cycle unless stalled; reports one verdict per frame.
// ============================================================================
// Throughput: one byte per cycle while the queue has room; a result can leave
// every cycle that out_stall_i is low. Path: the queue is written at the final
// byte transfer, and the output register loads from the queue head when free.
// Reset: rst_ni clears the parse state, the queue and the output valid,
// and loads the configuration registers with their default values.
// in_stall_o is high only while the summary queue is full.
// ============================================================================
module eth_ipv4_tcp_http_classifier import ethcls_pkg::*; #(
  parameter int MaxFrame   = MAX_FRAME_DEFAULT,
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Byte stream input.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            frame_byte_i,
  input  logic                  end_of_frame_i,
  // Verdict output.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            verdict_o,
  output logic [4:0]            ip_offset_o,
  output logic [6:0]            tcp_offset_o,
  output logic [7:0]            payload_offset_o,
  output logic [11:0]           kept_length_o,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  frame_sum_t push_sum, head_sum;
  logic       accept, push, pop, q_empty, q_full;

  // A byte transfer happens whenever the queue has room. The front end keeps
  // parsing while the back end waits on a stalled output, so a burst of short
  // frames only stalls the input once the queue and output register are full.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  ethcls_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The front end tracks header fields by byte position. The VLAN decision
  // uses the configured tag ethertype at the second ethertype byte.
  ethcls_front #(
    .MaxFrame (MaxFrame)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_byte_i   (frame_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .cfg_i          (cfg),
    .push_o         (push),
    .sum_o          (push_sum)
  );

  ethcls_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_sum),
    .pop_i       (pop),
    .head_o      (head_sum),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // The back end applies the remaining settings when the summary is taken.
  // The user must change settings only while the block is idle; the block
  // does not enforce this. Then they match the values in force at the final byte.
  ethcls_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_sum),
    .empty_i          (q_empty),
    .cfg_i            (cfg),
    .pop_o            (pop),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .verdict_o        (verdict_o),
    .ip_offset_o      (ip_offset_o),
    .tcp_offset_o     (tcp_offset_o),
    .payload_offset_o (payload_offset_o),
    .kept_length_o    (kept_length_o)
  );

endmodule

// ===== hdl/ethcls_checker.sv =====
// ============================================================================
// Ethernet classifier port checker
// Concurrent checks on the result port, bound to the classifier top level.
// ============================================================================
module ethcls_checker import ethcls_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  verdict_o,
  input logic [4:0]  ip_offset_o,
  input logic [6:0]  tcp_offset_o,
  input logic [7:0]  payload_offset_o,
  input logic [11:0] kept_length_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o) &&
      $stable(ip_offset_o) && $stable(tcp_offset_o) &&
      $stable(payload_offset_o) && $stable(kept_length_o))
    else $error("stalled result changed");

  // Frames that are not IPv4, or too short, report no offsets and no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_NOT_IPV4 || verdict_o == VERDICT_SHORT) |->
      ip_offset_o == '0 && tcp_offset_o == '0 && payload_offset_o == '0 &&
      kept_length_o == '0)
    else $error("dropped frame reports offsets or length");

  // Only HTTP frames carry a payload offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != VERDICT_TCP_HTTP |-> payload_offset_o == '0)
    else $error("payload offset on a non-HTTP frame");

  // Any IPv4 verdict points at one of the two possible IP header positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_NOT_TCP || verdict_o == VERDICT_TCP_OTHER ||
      verdict_o == VERDICT_TCP_HTTP) |-> ip_offset_o == IPO_PLAIN ||
      ip_offset_o == IPO_VLAN)
    else $error("bad IP header offset");

endmodule

bind eth_ipv4_tcp_http_classifier ethcls_checker u_checker (.*);

// ===== verif/tb.sv =====
// ============================================================================
// Frame classifier regression bench
// Streams Ethernet frames into the classifier one byte per transfer and
// checks every verdict against a cycle-free model of the parser kept in
// this bench. Covers directed corner frames, then random frames under
// several register settings, with random idling and back-pressure.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ethcls_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 5;
  // Spare clocks that wait_idle lets pass once every verdict is back.
  localparam int DRAIN_CYCLES  = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BYTES  = 100;
  localparam int RANDOM_FRAMES = 2;
  localparam int BURST_FRAMES  = 8;
  localparam int FRAME_LIMIT   = MAX_FRAME_DEFAULT;

  // One byte of the input stream, as the sender will present it.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } byte_item_t;

  // One verdict transfer, field by field.
  typedef struct packed {
    verdict_e    verdict;
    logic [4:0]  ip_off;
    logic [6:0]  tcp_off;
    logic [7:0]  pay_off;
    logic [11:0] kept;
  } frame_verdict_t;

  // --------------------------------------------------------------------------
  // Block signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            frame_byte_i   = 8'h00;
  logic                  end_of_frame_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [2:0]            verdict_o;
  logic [4:0]            ip_offset_o;
  logic [6:0]            tcp_offset_o;
  logic [7:0]            payload_offset_o;
  logic [11:0]           kept_length_o;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  eth_ipv4_tcp_http_classifier uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .frame_byte_i    (frame_byte_i),
    .end_of_frame_i  (end_of_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .verdict_o       (verdict_o),
    .ip_offset_o     (ip_offset_o),
    .tcp_offset_o    (tcp_offset_o),
    .payload_offset_o(payload_offset_o),
    .kept_length_o   (kept_length_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state.
  // --------------------------------------------------------------------------
  byte_item_t     frame_bytes_q[$];  // bytes waiting for the sender
  frame_verdict_t verdict_q[$];      // verdicts predicted but not yet seen
  logic [7:0]     frame_buf[];       // scratch space while a frame is built

  // Register values as the block holds them, updated after each write.
  cfg_t live_cfg = '{copy_limit:     RST_COPY_LIMIT,
                     http_port:      RST_HTTP_PORT,
                     ipv4_ethertype: RST_IPV4_ETHERTYPE,
                     vlan_ethertype: RST_VLAN_ETHERTYPE,
                     tcp_protocol:   RST_TCP_PROTOCOL};

  // Parse state of the frame in flight, cleared after every final byte.
  int          cur_index = 0;
  logic        cur_vlan  = 1'b0;
  logic [15:0] cur_type  = '0;
  logic [3:0]  cur_ihl   = '0;
  logic [7:0]  cur_proto = '0;
  logic [15:0] cur_dport = '0;
  logic [3:0]  cur_doff  = '0;

  // Transfer flags, set at the rising edge and read at the falling edge.
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;

  int err_count     = 0;
  int cycle_count   = 0;
  int bytes_queued  = 0;
  int frames_queued = 0;
  int tx_wait       = 0;
  bit tx_calm       = 1'b0;
  int rx_wait       = 0;
  int rx_hold       = 0;
  bit rx_calm       = 1'b0;
  // The stimulus asks for a long receiver hold by bumping hold_req; the
  // receiver notices the difference to hold_ack and starts counting.
  int hold_req      = 0;
  int hold_ack      = 0;

  always #(CLK_HALF) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Reporting. Every failed comparison ends up here as one line.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // --------------------------------------------------------------------------
  // Parser model. It sees each accepted byte, updates the header fields it
  // has captured so far, and on the final byte of a frame works out the
  // verdict that the block must report. It returns 1 when a verdict is due.
  // --------------------------------------------------------------------------
  function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                       output frame_verdict_t res);
    int ipo;
    int tcpo;
    int len;
    int pay;
    int kept;
    res = '0;
    // Bytes past the frame maximum are counted no further and never treated
    // as header positions.
    if (cur_index < FRAME_LIMIT) begin
      ipo  = cur_vlan ? int'(IPO_VLAN) : int'(IPO_PLAIN);
      tcpo = ipo + 4 * int'(cur_ihl);
      if (cur_index == ETYPE_HI_POS || cur_index == ETYPE_LO_POS ||
          (cur_vlan && (cur_index == INNER_HI_POS || cur_index == INNER_LO_POS))) begin
        cur_type = {cur_type[7:0], b};
      end
      // The tag decision uses the register value at the second type byte.
      if (cur_index == ETYPE_LO_POS) begin
        cur_vlan = (cur_type == live_cfg.vlan_ethertype);
      end
      if (cur_index == ipo) begin
        cur_ihl = b[3:0];
      end
      if (cur_index == ipo + PROTO_OFS) begin
        cur_proto = b;
      end
      // TCP positions only count once the IHL byte itself has gone by.
      if (cur_index > ipo) begin
        if (cur_index == tcpo + DPORT_HI_OFS || cur_index == tcpo + DPORT_LO_OFS) begin
          cur_dport = {cur_dport[7:0], b};
        end
        if (cur_index == tcpo + DOFS_OFS) begin
          cur_doff = b[7:4];
        end
      end
      cur_index++;
    end
    if (!last) begin
      return 1'b0;
    end
    len         = cur_index;
    ipo         = cur_vlan ? int'(IPO_VLAN) : int'(IPO_PLAIN);
    tcpo        = ipo + 4 * int'(cur_ihl);
    pay         = 0;
    kept        = 0;
    res.verdict = VERDICT_SHORT;
    // Each test below needs the fields the earlier ones have passed, and a
    // frame that stops before the next needed field is short.
    if (len < int'(IPO_PLAIN) || (cur_vlan && len < int'(IPO_VLAN))) begin
      ipo  = 0;
      tcpo = 0;
    end else if (cur_type != live_cfg.ipv4_ethertype) begin
      res.verdict = VERDICT_NOT_IPV4;
      ipo         = 0;
      tcpo        = 0;
    end else if (len < ipo + NEED_PROTO) begin
      ipo  = 0;
      tcpo = 0;
    end else if (cur_proto != live_cfg.tcp_protocol) begin
      res.verdict = VERDICT_NOT_TCP;
      tcpo        = 0;
    end else if (len < tcpo + NEED_DPORT) begin
      ipo  = 0;
      tcpo = 0;
    end else if (cur_dport != live_cfg.http_port) begin
      res.verdict = VERDICT_TCP_OTHER;
      kept        = len < int'(live_cfg.copy_limit) ? len : int'(live_cfg.copy_limit);
    end else if (len < tcpo + NEED_DOFS) begin
      ipo  = 0;
      tcpo = 0;
    end else begin
      res.verdict = VERDICT_TCP_HTTP;
      pay         = tcpo + 4 * int'(cur_doff);
      kept        = len < int'(live_cfg.copy_limit) ? len : int'(live_cfg.copy_limit);
    end
    res.ip_off  = 5'(ipo);
    res.tcp_off = 7'(tcpo);
    res.pay_off = 8'(pay);
    res.kept    = 12'(kept);
    cur_index   = 0;
    cur_vlan    = 1'b0;
    cur_type    = '0;
    cur_ihl     = '0;
    cur_proto   = '0;
    cur_dport   = '0;
    cur_doff    = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge it notes which transfers happen. An input
  // transfer feeds the model; an output transfer is compared with the
  // oldest predicted verdict.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    frame_verdict_t res;
    frame_verdict_t want;
    if (rst_ni) begin
      in_taken  = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      if (in_taken && classify_byte(frame_byte_i, end_of_frame_i, res)) begin
        verdict_q.push_back(res);
      end
      if (out_taken) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0d arrived with no frame pending",
                                    verdict_o));
        end else begin
          want = verdict_q.pop_front();
          check_field("verdict", verdict_o, want.verdict);
          check_field("ip_offset", ip_offset_o, want.ip_off);
          check_field("tcp_offset", tcp_offset_o, want.tcp_off);
          check_field("payload_offset", payload_offset_o, want.pay_off);
          check_field("kept_length", kept_length_o, want.kept);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Between transfers it idles at random, except in
  // calm stretches where it offers a byte every cycle. Once valid is up the
  // byte stays put until the block takes it.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : sender
    byte_item_t item;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid_i <= 1'b0;
      end else if (frame_bytes_q.size() != 0) begin
        item = frame_bytes_q.pop_front();
        frame_byte_i   <= item.data;
        end_of_frame_i <= item.eof;
        in_valid_i     <= 1'b1;
        if ($urandom_range(0, 63) == 0) begin
          tx_calm = !tx_calm;
        end
        tx_wait = tx_calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. After each verdict transfer it may stall at random, with calm
  // stretches of no stall. On request it holds off for a long
  // stretch so that the summary queue fills and the input stalls.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        rx_hold  = HOLD_CYCLES;
      end
      if (out_taken) begin
        if ($urandom_range(0, 63) == 0) begin
          rx_calm = !rx_calm;
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // A run that hangs ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("eth_ipv4_tcp_http_classifier regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes: setup cycle, then access cycle until pready.
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COPY_LIMIT:     live_cfg.copy_limit     = value[11:0];
      REG_HTTP_PORT:      live_cfg.http_port      = value[15:0];
      REG_IPV4_ETHERTYPE: live_cfg.ipv4_ethertype = value[15:0];
      REG_VLAN_ETHERTYPE: live_cfg.vlan_ethertype = value[15:0];
      REG_TCP_PROTOCOL:   live_cfg.tcp_protocol   = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int copy_limit, input int http_port,
                            input int ipv4_type, input int vlan_type,
                            input int tcp_proto);
    apb_write(REG_COPY_LIMIT, copy_limit);
    apb_write(REG_HTTP_PORT, http_port);
    apb_write(REG_IPV4_ETHERTYPE, ipv4_type);
    apb_write(REG_VLAN_ETHERTYPE, vlan_type);
    apb_write(REG_TCP_PROTOCOL, tcp_proto);
  endtask

  // Waits until every byte is taken and every verdict has come back, then
  // lets the block settle before it returns.
  task automatic wait_idle();
    while (frame_bytes_q.size() != 0 || in_valid_i || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Frame building. A frame starts as random bytes; a structured frame then
  // gets its header fields placed, as far as its length reaches.
  // --------------------------------------------------------------------------
  function automatic void put_byte(input int pos, input logic [7:0] v);
    if (pos < frame_buf.size()) begin
      frame_buf[pos] = v;
    end
  endfunction

  task automatic add_frame(input bit structured, input bit vlan,
                           input logic [15:0] etype, input logic [3:0] ihl,
                           input logic [7:0] proto, input logic [15:0] dport,
                           input logic [3:0] doff, input int len);
    byte_item_t item;
    int         ipo;
    int         tcpo;
    int         k;
    frame_buf = new[len];
    for (k = 0; k < len; k++) begin
      frame_buf[k] = 8'($urandom_range(0, 255));
    end
    if (structured) begin
      ipo  = vlan ? int'(IPO_VLAN) : int'(IPO_PLAIN);
      tcpo = ipo + 4 * int'(ihl);
      if (vlan) begin
        put_byte(ETYPE_HI_POS, live_cfg.vlan_ethertype[15:8]);
        put_byte(ETYPE_LO_POS, live_cfg.vlan_ethertype[7:0]);
        put_byte(INNER_HI_POS, etype[15:8]);
        put_byte(INNER_LO_POS, etype[7:0]);
      end else begin
        put_byte(ETYPE_HI_POS, etype[15:8]);
        put_byte(ETYPE_LO_POS, etype[7:0]);
      end
      put_byte(ipo, {4'h4, ihl});
      put_byte(ipo + PROTO_OFS, proto);
      put_byte(tcpo + DPORT_HI_OFS, dport[15:8]);
      put_byte(tcpo + DPORT_LO_OFS, dport[7:0]);
      put_byte(tcpo + DOFS_OFS, {doff, 4'($urandom_range(0, 15))});
    end
    for (k = 0; k < len; k++) begin
      item.data = frame_buf[k];
      item.eof  = (k == len - 1);
      frame_bytes_q.push_back(item);
    end
    bytes_queued += len;
    frames_queued++;
  endtask

  // Mostly well-formed frames that match the current registers, so that the
  // parse gets deep, with some noise, foreign types and truncated frames.
  task automatic add_random_frame();
    bit          vlan;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [3:0]  doff;
    int          need;
    int          len;
    vlan  = 1'($urandom_range(0, 1));
    etype = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                        : live_cfg.ipv4_ethertype;
    ihl   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4))
                                        : 4'($urandom_range(5, 15));
    proto = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                        : live_cfg.tcp_protocol;
    dport = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                        : live_cfg.http_port;
    doff  = 4'($urandom_range(0, 15));
    need  = (vlan ? int'(IPO_VLAN) : int'(IPO_PLAIN)) + 4 * int'(ihl) + NEED_DOFS;
    len   = ($urandom_range(0, 6) == 0) ? $urandom_range(1, need)
                                        : need + $urandom_range(0, 40);
    if ($urandom_range(0, 9) == 0) begin
      add_frame(1'b0, vlan, etype, ihl, proto, dport, doff, $urandom_range(1, 80));
    end else begin
      add_frame(1'b1, vlan, etype, ihl, proto, dport, doff, len);
    end
  endtask

  task automatic run_random();
    int byte_goal;
    int frame_goal;
    byte_goal  = bytes_queued + RANDOM_BYTES;
    frame_goal = frames_queued + RANDOM_FRAMES;
    while (bytes_queued < byte_goal || frames_queued < frame_goal) begin
      add_random_frame();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. One reset, then directed frames under the reset registers,
  // then phases of random frames, each under new register values that are
  // written only once the block has gone idle.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] ip4;
    logic [15:0] web;
    logic [7:0]  tcp;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ip4 = live_cfg.ipv4_ethertype;
    web = live_cfg.http_port;
    tcp = live_cfg.tcp_protocol;

    // Complete frames of each verdict other than short, with and without a tag.
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 54);
    add_frame(1'b1, 1'b1, ip4, 4'd5, tcp, web, 4'd8, 64);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, 16'd443, 4'd5, 60);
    add_frame(1'b1, 1'b0, ip4, 4'd5, 8'd17, web, 4'd5, 60);
    add_frame(1'b1, 1'b0, 16'h86dd, 4'd5, tcp, web, 4'd5, 60);
    add_frame(1'b1, 1'b1, 16'h0806, 4'd5, tcp, web, 4'd5, 60);
    // Frames cut before needed fields. The port 22 frame ends after its
    // port; the last ends on the data offset byte, and both are complete.
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 1);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 13);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 14);
    add_frame(1'b1, 1'b1, ip4, 4'd5, tcp, web, 4'd5, 17);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 23);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 37);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, 16'd22, 4'd5, 38);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 46);
    add_frame(1'b1, 1'b0, ip4, 4'd5, tcp, web, 4'd5, 47);
    // An IHL below five is taken as it stands.
    add_frame(1'b1, 1'b0, ip4, 4'd0, tcp, web, 4'd3, 40);
    add_frame(1'b1, 1'b1, ip4, 4'd2, tcp, web, 4'd0, 50);
    // Largest header offsets: tag, IHL 15 and data offset 15.
    add_frame(1'b1, 1'b1, ip4, 4'd15, tcp, web, 4'd15, 160);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(2048, 80, 16'h0800, 16'h8100, 6);
        1: set_config(0, 0, 16'hffff, 16'h0000, 255);
        2: set_config(1, 65535, 16'h0000, 16'hffff, 0);
        3: set_config(60, 8080, 16'h86dd, 16'h88a8, 17);
        default: set_config($urandom_range(0, 2048), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 255));
      endcase
      // A small copy limit still lets the whole frame be parsed; a frame
      // longer than the limit shows the clip.
      if (phase == 2 || phase == 3) begin
        add_frame(1'b1, 1'b0, live_cfg.ipv4_ethertype, 4'd5, live_cfg.tcp_protocol,
                  live_cfg.http_port, 4'd5, 70);
      end
      // A burst of tiny frames at the head of the backlog fills the summary
      // queue quickly while the receiver holds off, so the input stalls.
      if (phase == 1 || phase == 4) begin
        repeat (BURST_FRAMES) begin
          add_frame(1'b0, 1'b0, 16'h0000, 4'd0, 8'h00, 16'h0000, 4'd0,
                    $urandom_range(1, 12));
        end
      end
      run_random();
      if (phase == 1 || phase == 4) begin
        hold_req++;
      end
      wait_idle();
    end

    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    end
    if (err_count == 0) begin
      $display("eth_ipv4_tcp_http_classifier regression: pass");
    end else begin
      $display("eth_ipv4_tcp_http_classifier regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ethcls_pkg.sv
hdl/ethcls_regs.sv
hdl/ethcls_front.sv
hdl/ethcls_queue.sv
hdl/ethcls_back.sv
hdl/eth_ipv4_tcp_http_classifier.sv
hdl/ethcls_checker.sv
verif/tb.sv
